>>> hdl/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg: shared types, constants and microcode for the closure engine
// Holds the control word layout, the status flags and the program ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package btc_pkg;

    localparam int MAX_NODES_DEF = 64;  // default node capacity
    localparam int NODE_W        = 6;   // width of a node index field
    localparam int SIZE_W        = 7;   // width of the active size register
    localparam int REACH_W       = 64;  // width of an emitted reachability row
    localparam int CFG_AW        = 2;   // APB address width
    localparam int CFG_DW        = 32;  // APB data width

    localparam logic [CFG_AW-1:0] REG_ACTIVE_ADDR = 2'd0;

    // Program counter and step addresses.
    localparam int UC_PCW = 4;
    localparam int UC_LEN = 12;

    localparam logic [UC_PCW-1:0] UC_IDLE     = 4'd0;
    localparam logic [UC_PCW-1:0] UC_EDGE     = 4'd1;
    localparam logic [UC_PCW-1:0] UC_CL_INIT  = 4'd2;
    localparam logic [UC_PCW-1:0] UC_PIV_RD   = 4'd3;
    localparam logic [UC_PCW-1:0] UC_PIV_LD   = 4'd4;
    localparam logic [UC_PCW-1:0] UC_ROW_UPD  = 4'd5;
    localparam logic [UC_PCW-1:0] UC_PIV_NEXT = 4'd6;
    localparam logic [UC_PCW-1:0] UC_EM_INIT  = 4'd7;
    localparam logic [UC_PCW-1:0] UC_EM_RD    = 4'd8;
    localparam logic [UC_PCW-1:0] UC_EM_OUT   = 4'd9;
    localparam logic [UC_PCW-1:0] UC_EM_NEXT  = 4'd10;
    localparam logic [UC_PCW-1:0] UC_CLEAR    = 4'd11;

    typedef enum logic [2:0] {
        RD_NONE     = 3'd0,
        RD_FROM     = 3'd1,
        RD_PIVOT    = 3'd2,
        RD_ROW      = 3'd3,
        RD_ROW_NEXT = 3'd4
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_EDGE = 2'd1,
        WR_UPD  = 2'd2
    } t_wr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_CLR  = 2'd1,
        CNT_INC  = 2'd2
    } t_cnt_op;

    typedef enum logic [2:0] {
        COND_NEVER      = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_NO_INPUT   = 3'd2,
        COND_NOT_FINAL  = 3'd3,
        COND_I_NOT_LAST = 3'd4,
        COND_K_NOT_LAST = 3'd5,
        COND_OUT_BUSY   = 3'd6
    } t_cond;

    typedef struct packed {
        logic              accept;
        t_rd_sel           rd_sel;
        t_wr_sel           wr_sel;
        logic              ld_pivot;
        t_cnt_op           i_op;
        t_cnt_op           k_op;
        logic              emit;
        logic              clear;
        t_cond             cond;
        logic [UC_PCW-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic fin;
        logic i_last;
        logic k_last;
        logic out_busy;
    } t_flags;

    // The program: load edges, run Warshall pivots, emit rows, clear.
    function automatic t_ctrl ucode(input logic [UC_PCW-1:0] pc);
        t_ctrl w;
        w = '0;
        case (pc)
            UC_IDLE: begin
                w.accept = 1'b1;
                w.rd_sel = RD_FROM;
                w.cond   = COND_NO_INPUT;
                w.target = UC_IDLE;
            end
            UC_EDGE: begin
                w.wr_sel = WR_EDGE;
                w.cond   = COND_NOT_FINAL;
                w.target = UC_IDLE;
            end
            UC_CL_INIT: begin
                w.i_op = CNT_CLR;
                w.k_op = CNT_CLR;
            end
            UC_PIV_RD: begin
                w.rd_sel = RD_PIVOT;
            end
            UC_PIV_LD: begin
                w.ld_pivot = 1'b1;
                w.rd_sel   = RD_ROW;
            end
            UC_ROW_UPD: begin
                w.wr_sel = WR_UPD;
                w.rd_sel = RD_ROW_NEXT;
                w.i_op   = CNT_INC;
                w.cond   = COND_I_NOT_LAST;
                w.target = UC_ROW_UPD;
            end
            UC_PIV_NEXT: begin
                w.i_op   = CNT_CLR;
                w.k_op   = CNT_INC;
                w.cond   = COND_K_NOT_LAST;
                w.target = UC_PIV_RD;
            end
            UC_EM_INIT: begin
                w.i_op = CNT_CLR;
                w.k_op = CNT_CLR;
            end
            UC_EM_RD: begin
                w.rd_sel = RD_ROW;
            end
            UC_EM_OUT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = UC_EM_OUT;
            end
            UC_EM_NEXT: begin
                w.i_op   = CNT_INC;
                w.cond   = COND_I_NOT_LAST;
                w.target = UC_EM_RD;
            end
            UC_CLEAR: begin
                w.clear  = 1'b1;
                w.i_op   = CNT_CLR;
                w.cond   = COND_ALWAYS;
                w.target = UC_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = UC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/btc_ram.sv
// ----------------------------------------------------------------------------
// btc_ram: generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

`default_nettype wire

>>> hdl/btc_useq.sv
// ----------------------------------------------------------------------------
// btc_useq: microcode sequencer
// Step counter, program ROM lookup and conditional jump evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module btc_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire btc_pkg::t_flags i_flags,
    output btc_pkg::t_ctrl       o_ctrl
);

    logic [btc_pkg::UC_PCW-1:0] r_pc;
    logic [btc_pkg::UC_PCW-1:0] n_pc;
    btc_pkg::t_ctrl             ctrl;
    logic                       take;

    assign ctrl = btc_pkg::ucode(r_pc);

    always_comb begin
        case (ctrl.cond)
            btc_pkg::COND_NEVER:      take = 1'b0;
            btc_pkg::COND_ALWAYS:     take = 1'b1;
            btc_pkg::COND_NO_INPUT:   take = !i_flags.in_valid;
            btc_pkg::COND_NOT_FINAL:  take = !i_flags.fin;
            btc_pkg::COND_I_NOT_LAST: take = !i_flags.i_last;
            btc_pkg::COND_K_NOT_LAST: take = !i_flags.k_last;
            btc_pkg::COND_OUT_BUSY:   take = i_flags.out_busy;
            default:                  take = 1'b0;
        endcase
        n_pc = take ? ctrl.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= btc_pkg::UC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;

    // The program never runs off the end of the ROM.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc < btc_pkg::UC_PCW'(btc_pkg::UC_LEN))
        else $error("step counter beyond program");

    // Input beats are only taken at the idle step.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.accept |-> r_pc == btc_pkg::UC_IDLE)
        else $error("input accepted outside idle step");

endmodule

`default_nettype wire

>>> hdl/btc_dpath.sv
// ----------------------------------------------------------------------------
// btc_dpath: matrix datapath
// Row RAM with per-row valid bits, pivot register, counters and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module btc_dpath #(
    parameter int MAX_NODES = btc_pkg::MAX_NODES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire btc_pkg::t_ctrl              i_ctrl,
    input  wire logic [btc_pkg::SIZE_W-1:0]  i_size,
    input  wire logic                        i_in_valid,
    input  wire logic [btc_pkg::NODE_W-1:0]  i_from,
    input  wire logic [btc_pkg::NODE_W-1:0]  i_to,
    input  wire logic                        i_edge_value,
    input  wire logic                        i_final,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic      [btc_pkg::NODE_W-1:0]  o_row_index,
    output logic      [btc_pkg::REACH_W-1:0] o_reach_bits,
    output logic                             o_last_row,
    output logic                             o_dropped,
    output btc_pkg::t_flags                  o_flags
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [btc_pkg::NODE_W-1:0]  r_from;
    logic [btc_pkg::NODE_W-1:0]  r_to;
    logic                        r_val;
    logic                        r_fin;
    logic                        r_edge_drop;
    logic                        r_drop_flag;
    logic [MAX_NODES-1:0]        r_valid;
    logic                        r_rd_vld;
    logic [CW-1:0]               r_i;
    logic [CW-1:0]               r_k;
    logic [MAX_NODES-1:0]        r_pivot;
    logic                        r_out_valid;
    logic [btc_pkg::NODE_W-1:0]  r_out_row;
    logic [btc_pkg::REACH_W-1:0] r_out_bits;
    logic                        r_out_last;
    logic                        r_out_drop;

    logic [CW-1:0]        size_c;
    logic [CW-1:0]        last_idx;
    logic [CW-1:0]        i_next;
    logic [MAX_NODES-1:0] col_mask;
    logic [MAX_NODES-1:0] edge_bit;
    logic                 in_fire;
    logic                 out_fire;
    logic                 out_busy;
    logic                 ld_out;
    logic                 edge_drop;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [MAX_NODES-1:0] wr_data;
    logic [MAX_NODES-1:0] q_raw;
    logic [MAX_NODES-1:0] q_eff;
    logic [MAX_NODES-1:0] q_cl;

    assign size_c   = CW'(i_size);
    assign last_idx = size_c - 1'b1;
    assign i_next   = r_i + 1'b1;
    assign in_fire  = i_ctrl.accept && i_in_valid;
    assign out_fire = r_out_valid && i_out_ready;
    assign out_busy = r_out_valid && !out_fire;
    assign ld_out   = i_ctrl.emit && !out_busy;
    assign edge_drop = ({1'b0, i_from} >= i_size) || ({1'b0, i_to} >= i_size);
    assign edge_bit = {{(MAX_NODES-1){1'b0}}, 1'b1} << r_to;

    always_comb begin
        for (int c = 0; c < MAX_NODES; c++) begin
            col_mask[c] = CW'(c) < size_c;
        end
    end

    // Read address selection.
    always_comb begin
        case (i_ctrl.rd_sel)
            btc_pkg::RD_FROM:     rd_addr = AW'(i_from);
            btc_pkg::RD_PIVOT:    rd_addr = r_k[AW-1:0];
            btc_pkg::RD_ROW:      rd_addr = r_i[AW-1:0];
            btc_pkg::RD_ROW_NEXT: rd_addr = i_next[AW-1:0];
            default:              rd_addr = '0;
        endcase
        rd_en = (i_ctrl.rd_sel != btc_pkg::RD_NONE)
             && ((i_ctrl.rd_sel != btc_pkg::RD_FROM) || in_fire);
    end

    // Rows never written since the last clear read as zero.
    assign q_eff = r_rd_vld ? q_raw : '0;
    assign q_cl  = q_eff & col_mask;

    always_comb begin
        case (i_ctrl.wr_sel)
            btc_pkg::WR_EDGE: begin
                wr_en   = !r_edge_drop;
                wr_addr = AW'(r_from);
                wr_data = r_val ? (q_eff | edge_bit) : (q_eff & ~edge_bit);
            end
            btc_pkg::WR_UPD: begin
                wr_en   = 1'b1;
                wr_addr = r_i[AW-1:0];
                wr_data = q_cl[r_k[AW-1:0]] ? (q_cl | r_pivot) : q_cl;
            end
            default: begin
                wr_en   = 1'b0;
                wr_addr = '0;
                wr_data = '0;
            end
        endcase
    end

    btc_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_rows (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (q_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_flag <= 1'b0;
            r_valid     <= '0;
            r_i         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_fin       <= 1'b0;
            r_edge_drop <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_fin       <= i_final;
                r_edge_drop <= edge_drop;
                if (edge_drop) begin
                    r_drop_flag <= 1'b1;
                end
            end
            if (rd_en) begin
                r_rd_vld <= (rd_addr <= AW'(MAX_NODES - 1)) && r_valid[rd_addr];
            end
            if (i_ctrl.clear) begin
                r_valid     <= '0;
                r_drop_flag <= 1'b0;
            end else if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            case (i_ctrl.i_op)
                btc_pkg::CNT_CLR: r_i <= '0;
                btc_pkg::CNT_INC: r_i <= i_next;
                default:          r_i <= r_i;
            endcase
            case (i_ctrl.k_op)
                btc_pkg::CNT_CLR: r_k <= '0;
                btc_pkg::CNT_INC: r_k <= r_k + 1'b1;
                default:          r_k <= r_k;
            endcase
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_from <= i_from;
            r_to   <= i_to;
            r_val  <= i_edge_value;
        end
        if (i_ctrl.ld_pivot) begin
            r_pivot <= q_cl;
        end
        if (ld_out) begin
            r_out_row  <= btc_pkg::NODE_W'(r_i);
            r_out_bits <= btc_pkg::REACH_W'(q_cl);
            r_out_last <= r_i == last_idx;
            r_out_drop <= r_drop_flag;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_index  = r_out_row;
    assign o_reach_bits = r_out_bits;
    assign o_last_row   = r_out_last;
    assign o_dropped    = r_out_drop;

    assign o_flags.in_valid = i_in_valid;
    assign o_flags.fin      = r_fin;
    assign o_flags.i_last   = r_i == last_idx;
    assign o_flags.k_last   = r_k == last_idx;
    assign o_flags.out_busy = out_busy;

    // A row update never reads the row it writes in the same cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> wr_addr != rd_addr)
        else $error("row RAM read and write collide");

    // A new row is loaded only when the output stage is free or draining.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_out |-> (!r_out_valid || i_out_ready))
        else $error("pending output beat overwritten");

endmodule

`default_nettype wire

>>> hdl/bit_matrix_transitive_closure_top.sv
// ----------------------------------------------------------------------------
// bit_matrix_transitive_closure_top: reachability closure of a bit matrix
// Loads edges into an adjacency matrix, closes it and streams out the rows.
// ----------------------------------------------------------------------------
// Usage
//   Edges arrive on the s_axis channel, one per beat. Each beat sets or
//   clears one bit (from_node, to_node) of the adjacency matrix. Edges that
//   name a node at or beyond the active size are not stored and raise a flag
//   that is reported with every row of the next burst. The beat with tlast
//   high is the final edge: it is applied and then the matrix is replaced by
//   its transitive closure in Warshall order.
//   The closed matrix leaves on m_axis, one beat per row, rows 0 to N-1,
//   with tlast on row N-1. The matrix and the flag are then cleared.
//   An edge beat is a row RAM read at the idle step, then a write back. The
//   closure is one setup step, then per pivot one read of the pivot row,
//   one load, one row read-modify-write per cycle and a step to the next
//   pivot. Each emitted row is a row read, an emit step and a step to the
//   next row, after a setup step. A stall on m_axis holds the sequencer at
//   the emit step; the output register keeps the current beat. Reset clears
//   the row valid bits, so the matrix reads as empty at once, and sets
//   active_nodes to 64. active_nodes is written over APB at address 0; the
//   user must write it only between loads, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_matrix_transitive_closure_top #(
    parameter int MAX_NODES = btc_pkg::MAX_NODES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // s_axis_tdata: [5:0] from_node, [11:6] to_node, [12] edge_value, [15:13] zero
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [15:0]                s_axis_tdata,
    input  wire logic                       s_axis_tlast,
    // m_axis_tdata: [5:0] row_index, [69:6] reach_bits, [71:70] zero
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic      [71:0]                m_axis_tdata,
    output logic                            m_axis_tlast,
    // m_axis_tuser: [0] dropped_any
    output logic      [0:0]                 m_axis_tuser,
    // APB configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [btc_pkg::CFG_AW-1:0] paddr,
    input  wire logic [btc_pkg::CFG_DW-1:0] pwdata,
    output logic      [btc_pkg::CFG_DW-1:0] prdata,
    output logic                            pready
);

    logic [btc_pkg::SIZE_W-1:0]  r_active_nodes;
    logic [btc_pkg::SIZE_W-1:0]  size_in_use;
    logic                        cfg_wr;
    btc_pkg::t_ctrl              ctrl;
    btc_pkg::t_flags             flags;
    logic [btc_pkg::NODE_W-1:0]  out_row;
    logic [btc_pkg::REACH_W-1:0] out_bits;
    logic                        out_drop;

    // Configuration register; the port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr == btc_pkg::REG_ACTIVE_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_nodes <= btc_pkg::SIZE_W'(64);
        end else if (cfg_wr) begin
            r_active_nodes <= pwdata[btc_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = (paddr == btc_pkg::REG_ACTIVE_ADDR)
                  ? btc_pkg::CFG_DW'(r_active_nodes) : '0;

    // The size in force is the register held to the range 1 .. MAX_NODES.
    always_comb begin
        if (r_active_nodes == '0) begin
            size_in_use = btc_pkg::SIZE_W'(1);
        end else if (r_active_nodes > btc_pkg::SIZE_W'(MAX_NODES)) begin
            size_in_use = btc_pkg::SIZE_W'(MAX_NODES);
        end else begin
            size_in_use = r_active_nodes;
        end
    end

    btc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    btc_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_size       (size_in_use),
        .i_in_valid   (s_axis_tvalid),
        .i_from       (s_axis_tdata[5:0]),
        .i_to         (s_axis_tdata[11:6]),
        .i_edge_value (s_axis_tdata[12]),
        .i_final      (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_row_index  (out_row),
        .o_reach_bits (out_bits),
        .o_last_row   (m_axis_tlast),
        .o_dropped    (out_drop),
        .o_flags      (flags)
    );

    assign s_axis_tready   = ctrl.accept;
    assign m_axis_tdata    = {2'b00, out_bits, out_row};
    assign m_axis_tuser[0] = out_drop;

endmodule

`default_nettype wire
